@@ rtl/abps_pkg.sv @@
package abps_pkg;

    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_PLAY = 2'd1;
    localparam logic [1:0] FUNC_TEST = 2'd2;

    localparam logic [1:0] PROF_STD   = 2'd0;
    localparam logic [1:0] PROF_QUIET = 2'd1;
    localparam logic [1:0] PROF_LOUD  = 2'd2;
    localparam logic [1:0] PROF_CFG   = 2'd3;

    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_QUEUED  = 3'd1;
    localparam logic [2:0] ST_GATED   = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_DROPPED = 3'd4;

    localparam logic [2:0] CFG_ENABLE   = 3'd0;
    localparam logic [2:0] CFG_MASK     = 3'd1;
    localparam logic [2:0] CFG_PROFILE  = 3'd2;
    localparam logic [2:0] CFG_Q_START  = 3'd3;
    localparam logic [2:0] CFG_Q_END    = 3'd4;
    localparam logic [2:0] CFG_CRIT_OVR = 3'd5;

    localparam int CFG_DATA_W = 14;

    localparam logic [3:0] EV_BOOT      = 4'd0;
    localparam logic [3:0] EV_CRIT_LOW  = 4'd1;
    localparam logic [3:0] NUM_EVENTS   = 4'd14;
    localparam logic [4:0] LAST_HOUR    = 5'd23;
    localparam logic [9:0] QUIET_TAP_MS = 10'd60;

    localparam logic [9:0] ROM_ON [0:13][0:3] = '{
        '{10'd80,  10'd160, 10'd240, 10'd0},
        '{10'd200, 10'd200, 10'd200, 10'd0},
        '{10'd100, 10'd100, 10'd0,   10'd0},
        '{10'd500, 10'd0,   10'd0,   10'd0},
        '{10'd150, 10'd150, 10'd0,   10'd0},
        '{10'd150, 10'd0,   10'd0,   10'd0},
        '{10'd80,  10'd80,  10'd0,   10'd0},
        '{10'd100, 10'd200, 10'd400, 10'd0},
        '{10'd300, 10'd300, 10'd300, 10'd0},
        '{10'd100, 10'd0,   10'd0,   10'd0},
        '{10'd80,  10'd80,  10'd0,   10'd0},
        '{10'd200, 10'd200, 10'd200, 10'd200},
        '{10'd50,  10'd0,   10'd0,   10'd0},
        '{10'd200, 10'd200, 10'd0,   10'd0}
    };

    localparam logic [9:0] ROM_OFF [0:13][0:3] = '{
        '{10'd80,  10'd80,  10'd0,   10'd0},
        '{10'd200, 10'd200, 10'd0,   10'd0},
        '{10'd50,  10'd0,   10'd0,   10'd0},
        '{10'd0,   10'd0,   10'd0,   10'd0},
        '{10'd150, 10'd0,   10'd0,   10'd0},
        '{10'd0,   10'd0,   10'd0,   10'd0},
        '{10'd80,  10'd80,  10'd0,   10'd0},
        '{10'd80,  10'd80,  10'd0,   10'd0},
        '{10'd300, 10'd300, 10'd0,   10'd0},
        '{10'd0,   10'd0,   10'd0,   10'd0},
        '{10'd80,  10'd0,   10'd0,   10'd0},
        '{10'd200, 10'd200, 10'd200, 10'd0},
        '{10'd0,   10'd0,   10'd0,   10'd0},
        '{10'd200, 10'd0,   10'd0,   10'd0}
    };

    // Off times scaled by two thirds and truncated, for the loud profile.
    localparam logic [9:0] ROM_OFF_LOUD [0:13][0:3] = '{
        '{10'd53,  10'd53,  10'd0,   10'd0},
        '{10'd133, 10'd133, 10'd0,   10'd0},
        '{10'd33,  10'd0,   10'd0,   10'd0},
        '{10'd0,   10'd0,   10'd0,   10'd0},
        '{10'd100, 10'd0,   10'd0,   10'd0},
        '{10'd0,   10'd0,   10'd0,   10'd0},
        '{10'd53,  10'd53,  10'd0,   10'd0},
        '{10'd53,  10'd53,  10'd0,   10'd0},
        '{10'd200, 10'd200, 10'd0,   10'd0},
        '{10'd0,   10'd0,   10'd0,   10'd0},
        '{10'd53,  10'd0,   10'd0,   10'd0},
        '{10'd133, 10'd133, 10'd133, 10'd0},
        '{10'd0,   10'd0,   10'd0,   10'd0},
        '{10'd133, 10'd0,   10'd0,   10'd0}
    };

    localparam logic [2:0] ROM_COUNT [0:13] = '{
        3'd3, 3'd3, 3'd2, 3'd1, 3'd2, 3'd1, 3'd2, 3'd3, 3'd3, 3'd1, 3'd2, 3'd4, 3'd1, 3'd2
    };

    localparam logic [1:0] ROM_REP [0:13] = '{
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd3, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1
    };

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_ON   = 3'b010,
        PH_OFF  = 3'b100
    } play_phase_t;

    typedef struct packed {
        logic       tick;
        logic       enq;
        logic [5:0] entry;
        logic [2:0] status;
    } front_req_t;

    typedef struct packed {
        logic full;
        logic nonempty;
        logic nonempty_next;
    } queue_stat_t;

    typedef struct packed {
        logic pop;
        logic level_next;
        logic active_next;
    } player_stat_t;

    typedef struct packed {
        logic       level;
        logic       busy;
        logic [2:0] status;
    } result_t;

    function automatic logic [2:0] pat_count(input logic [3:0] ev, input logic [1:0] prof);
        logic [2:0] n;
        n = 3'd1;
        if (prof != PROF_QUIET && ev < NUM_EVENTS) begin
            n = ROM_COUNT[ev];
        end
        return n;
    endfunction

    function automatic logic [1:0] pat_rep(input logic [3:0] ev, input logic [1:0] prof);
        logic [1:0] n;
        n = 2'd1;
        if (prof != PROF_QUIET && ev < NUM_EVENTS) begin
            n = ROM_REP[ev];
        end
        return n;
    endfunction

    function automatic logic [9:0] phase_len(input logic [3:0] ev, input logic [1:0] prof,
                                             input logic is_on, input logic [1:0] beat);
        logic [9:0] len;
        len = '0;
        if (prof == PROF_QUIET) begin
            len = is_on ? QUIET_TAP_MS : 10'd0;
        end else if (ev < NUM_EVENTS) begin
            if (is_on) begin
                len = ROM_ON[ev][beat];
                if (prof == PROF_LOUD) begin
                    len = len + (len >> 1);
                end
            end else begin
                len = (prof == PROF_LOUD) ? ROM_OFF_LOUD[ev][beat] : ROM_OFF[ev][beat];
            end
        end
        return len;
    endfunction

endpackage

@@ rtl/abps_front.sv @@
module abps_front
    import abps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  logic [1:0]            func,
    input  logic [3:0]            event_id,
    input  logic [1:0]            profile_sel,
    input  logic [4:0]            current_hour,
    input  logic                  time_valid,
    input  logic                  queue_full,
    output front_req_t            req
);

    logic                  enable_reg;
    logic [NUM_EVENTS-1:0] mask_reg;
    logic [1:0]            profile_reg;
    logic [4:0]            q_start_reg;
    logic [4:0]            q_end_reg;
    logic                  crit_ovr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b1;
            mask_reg     <= 14'd511;
            profile_reg  <= PROF_STD;
            q_start_reg  <= 5'd22;
            q_end_reg    <= 5'd7;
            crit_ovr_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_ENABLE:   enable_reg   <= cfg_data[0];
                CFG_MASK:     mask_reg     <= cfg_data[NUM_EVENTS-1:0];
                CFG_PROFILE:  profile_reg  <= (cfg_data[1:0] == PROF_CFG) ? PROF_STD
                                                                          : cfg_data[1:0];
                CFG_Q_START:  q_start_reg  <= (cfg_data[4:0] > LAST_HOUR) ? 5'd0 : cfg_data[4:0];
                CFG_Q_END:    q_end_reg    <= (cfg_data[4:0] > LAST_HOUR) ? 5'd0 : cfg_data[4:0];
                CFG_CRIT_OVR: crit_ovr_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic       quiet;
    logic       pass;
    logic [1:0] prof;
    logic       is_req;

    always_comb
    begin
        if (q_start_reg == q_end_reg || !time_valid)
        begin
            quiet = 1'b0;
        end
        else if (q_start_reg < q_end_reg)
        begin
            quiet = (current_hour >= q_start_reg) && (current_hour < q_end_reg);
        end
        else
        begin
            quiet = (current_hour >= q_start_reg) || (current_hour < q_end_reg);
        end
    end

    always_comb
    begin
        is_req = (func == FUNC_PLAY) || (func == FUNC_TEST);
        pass   = 1'b1;
        prof   = profile_reg;
        if (func == FUNC_TEST)
        begin
            prof = (profile_sel == PROF_CFG) ? profile_reg : profile_sel;
        end
        else if (event_id != EV_BOOT && event_id < NUM_EVENTS)
        begin
            // The quiet window is the last gate; critical low can be exempt from it.
            if (!enable_reg || !mask_reg[event_id])
            begin
                pass = 1'b0;
            end
            else if (quiet && !(event_id == EV_CRIT_LOW && crit_ovr_reg))
            begin
                pass = 1'b0;
            end
        end

        req.tick  = accept && (func == FUNC_TICK);
        req.enq   = 1'b0;
        req.entry = {prof, event_id};
        priority if (!is_req)
        begin
            req.status = ST_NONE;
        end
        else if (event_id >= NUM_EVENTS)
        begin
            req.status = ST_INVALID;
        end
        else if (!pass)
        begin
            req.status = ST_GATED;
        end
        else if (queue_full)
        begin
            req.status = ST_DROPPED;
        end
        else
        begin
            req.status = ST_QUEUED;
            req.enq    = accept;
        end
    end

endmodule

@@ rtl/abps_queue.sv @@
module abps_queue
    import abps_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [5:0]  wdata,
    input  logic        pop,
    output logic [5:0]  head_data,
    output queue_stat_t stat
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

    logic [5:0]    mem [QUEUE_DEPTH];
    logic [5:0]    head_data_reg;
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [AW-1:0] tail_reg;
    logic [AW-1:0] tail_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push) begin
            tail_next  = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end else if (pop) begin
            head_next  = (head_reg == LAST) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // The head entry is held in its own register so the player sees it at once.
    always_ff @(posedge clk) begin
        if (push) begin
            mem[tail_reg] <= wdata;
        end
        if (push && count_reg == '0) begin
            head_data_reg <= wdata;
        end else if (pop && count_reg > CW'(1)) begin
            head_data_reg <= mem[head_next];
        end
    end

    assign head_data          = head_data_reg;
    assign stat.full          = (count_reg == FULL_COUNT);
    assign stat.nonempty      = (count_reg != '0);
    assign stat.nonempty_next = (count_next != '0);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != FULL_COUNT) && !pop)
        else $error("push into full queue or with a pop");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && count_reg == CW'(1)) |=> (count_reg == '0))
        else $error("last pop did not empty the queue");

endmodule

@@ rtl/abps_player.sv @@
module abps_player
    import abps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         tick,
    input  logic         queue_nonempty,
    input  logic [5:0]   head_data,
    output player_stat_t stat
);

    play_phase_t ph_reg, ph_next, ph_mid;
    logic [3:0]  ev_reg, ev_next;
    logic [1:0]  prof_reg, prof_next;
    logic [1:0]  beat_reg, beat_next, beat_mid;
    logic [1:0]  rep_reg, rep_next, rep_mid;
    logic [9:0]  ms_reg, ms_next, ms_mid;
    logic [9:0]  ms_dec;
    logic [9:0]  off_len;
    logic [9:0]  on_len;
    logic [9:0]  first_len;
    logic [2:0]  nb;
    logic        wrap;
    logic        start;

    always_comb begin
        nb        = {1'b0, beat_reg} + 3'd1;
        ms_dec    = (ms_reg != '0) ? ms_reg - 10'd1 : ms_reg;
        off_len   = phase_len(ev_reg, prof_reg, 1'b0, beat_reg);
        on_len    = phase_len(ev_reg, prof_reg, 1'b1, nb[1:0]);
        first_len = phase_len(ev_reg, prof_reg, 1'b1, 2'd0);
        wrap      = (nb >= pat_count(ev_reg, prof_reg));

        ph_mid   = ph_reg;
        beat_mid = beat_reg;
        rep_mid  = rep_reg;
        ms_mid   = ms_reg;
        if (tick && ph_reg != PH_IDLE) begin
            ms_mid = ms_dec;
            if (ms_dec == '0) begin
                // An empty off phase falls through to the next beat.
                priority if (ph_reg == PH_ON && off_len != '0) begin
                    ph_mid = PH_OFF;
                    ms_mid = off_len;
                end else if (!wrap) begin
                    ph_mid   = PH_ON;
                    beat_mid = nb[1:0];
                    ms_mid   = on_len;
                end else if (rep_reg != '0) begin
                    ph_mid   = PH_ON;
                    beat_mid = '0;
                    rep_mid  = rep_reg - 2'd1;
                    ms_mid   = first_len;
                end else begin
                    ph_mid   = PH_IDLE;
                    beat_mid = '0;
                    ms_mid   = '0;
                end
            end
        end

        start     = tick && ph_mid == PH_IDLE && queue_nonempty;
        ph_next   = ph_mid;
        ev_next   = ev_reg;
        prof_next = prof_reg;
        beat_next = beat_mid;
        rep_next  = rep_mid;
        ms_next   = ms_mid;
        if (start) begin
            ev_next   = head_data[3:0];
            prof_next = head_data[5:4];
            beat_next = '0;
            rep_next  = pat_rep(head_data[3:0], head_data[5:4]) - 2'd1;
            ph_next   = PH_ON;
            ms_next   = phase_len(head_data[3:0], head_data[5:4], 1'b1, 2'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ph_reg   <= PH_IDLE;
            ev_reg   <= '0;
            prof_reg <= '0;
            beat_reg <= '0;
            rep_reg  <= '0;
            ms_reg   <= '0;
        end else begin
            ph_reg   <= ph_next;
            ev_reg   <= ev_next;
            prof_reg <= prof_next;
            beat_reg <= beat_next;
            rep_reg  <= rep_next;
            ms_reg   <= ms_next;
        end
    end

    assign stat.pop         = start;
    assign stat.level_next  = (ph_next == PH_ON);
    assign stat.active_next = (ph_next != PH_IDLE);

endmodule

@@ rtl/alert_buzzer_pattern_sequencer.sv @@
// Alert buzzer pattern sequencer. Each input item (a 1 ms tick, a play request or a test
// request) yields exactly one result, so with pop held high the block takes one item per
// clock. Requests are checked and gated on entry and stored in a request queue of
// QUEUE_DEPTH entries; ticks drive the pattern player, which pulls the oldest request when it
// goes idle. Results wait in a two-entry output buffer; full rises only when
// two results are waiting untaken. Configuration writes are taken in every cycle (cfg_ready
// is always high) and are meant to be issued while no item is in flight.
module alert_buzzer_pattern_sequencer
    import abps_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            func,
    input  logic [3:0]            event_id,
    input  logic [1:0]            profile_sel,
    input  logic [4:0]            current_hour,
    input  logic                  time_valid,
    output logic                  empty,
    input  logic                  pop,
    output logic                  buzzer_level,
    output logic                  busy_res,
    output logic [2:0]            request_status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic         accept;
    logic         out_take;
    front_req_t   req;
    queue_stat_t  q_stat;
    player_stat_t p_stat;
    logic [5:0]   head_data;
    result_t      res_new;
    result_t      out0_reg;
    result_t      out1_reg;
    logic [1:0]   out_cnt_reg;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;
    assign out_take  = pop && !empty;

    abps_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .func         (func),
        .event_id     (event_id),
        .profile_sel  (profile_sel),
        .current_hour (current_hour),
        .time_valid   (time_valid),
        .queue_full   (q_stat.full),
        .req          (req)
    );

    abps_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req.enq),
        .wdata     (req.entry),
        .pop       (p_stat.pop),
        .head_data (head_data),
        .stat      (q_stat)
    );

    abps_player u_player (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (req.tick),
        .queue_nonempty (q_stat.nonempty),
        .head_data      (head_data),
        .stat           (p_stat)
    );

    assign res_new.level  = p_stat.level_next;
    assign res_new.busy   = p_stat.active_next || q_stat.nonempty_next;
    assign res_new.status = req.status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_cnt_reg <= 2'd0;
        end
        else if (accept && !out_take)
        begin
            out_cnt_reg <= out_cnt_reg + 2'd1;
        end
        else if (out_take && !accept)
        begin
            out_cnt_reg <= out_cnt_reg - 2'd1;
        end
    end

    // Entry zero is the oldest waiting result; a transfer out shifts entry one down.
    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            if (accept && out_cnt_reg == 2'd1)
            begin
                out0_reg <= res_new;
            end
            else
            begin
                out0_reg <= out1_reg;
                if (accept)
                begin
                    out1_reg <= res_new;
                end
            end
        end
        else if (accept)
        begin
            if (out_cnt_reg == 2'd0)
            begin
                out0_reg <= res_new;
            end
            else
            begin
                out1_reg <= res_new;
            end
        end
    end

    assign full           = (out_cnt_reg == 2'd2);
    assign empty          = (out_cnt_reg == 2'd0);
    assign buzzer_level   = out0_reg.level;
    assign busy_res       = out0_reg.busy;
    assign request_status = out0_reg.status;

endmodule
